// File: hdl/assert_macros.svh
// Assertion macros used by the RTL engine module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/lssw_pkg.sv
// Shared types, constants and sine coefficients of the LED strip sine wave pattern core.
package lssw_pkg;

	// Defaults of the top-level parameters.
	localparam int DefNumWaves  = 6;
	localparam int DefPhaseBits = 16;

	// Strip length and the pixel index width that follows from it.
	localparam int MaxPixels = 1024;
	localparam int IndexW    = $clog2(MaxPixels);

	// Multiplier operand and product widths.
	localparam int MulW  = 31;
	localparam int ProdW = 2 * MulW;

	// Odd sine polynomial coefficients, Q30.
	localparam logic [MulW-1:0] SinA1 = 31'd1686629713;
	localparam logic [MulW-1:0] SinA3 = 31'd693598668;
	localparam logic [MulW-1:0] SinA5 = 31'd85569305;
	localparam logic [MulW-1:0] SinA7 = 31'd5026991;
	localparam logic [MulW-1:0] SinA9 = 31'd172272;

	// One in Q23, the clamp level of the wave sum.
	localparam int OneQ23 = 1 << 23;

	// Register reset values.
	localparam logic [15:0]        RstAnglePerPixel = 16'd1092;
	localparam logic signed [15:0] RstWaveThreshold = 16'sd32113;
	localparam logic [15:0]        RstWaveGain      = 16'd12800;
	localparam logic [7:0]         RstBlueLevel     = 8'd178;
	localparam logic [11:0]        RstPhaseStep     = 12'd21;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_ANGLE_PER_PIXEL = 3'd0,
		REG_WAVE_THRESHOLD  = 3'd1,
		REG_WAVE_GAIN       = 3'd2,
		REG_BLUE_LEVEL      = 3'd3,
		REG_PHASE_STEP      = 3'd4
	} lssw_reg_t;

	// Configuration registers as seen by the engine.
	typedef struct packed {
		logic [15:0]        angle_per_pixel;
		logic signed [15:0] wave_threshold;
		logic [15:0]        wave_gain;
		logic [7:0]         blue_level;
		logic [11:0]        phase_step;
	} lssw_cfg_t;

	// Result handed from the engine to the output register.
	typedef struct packed {
		logic              valid;
		logic [IndexW-1:0] index;
		logic [7:0]        red;
	} lssw_res_t;

	// Horner coefficients in the order they are applied after A9.
	function automatic logic [MulW-1:0] sin_coef(input logic [1:0] sel);
		logic [MulW-1:0] c;
		case (sel)
			2'd0: c = SinA7;
			2'd1: c = SinA5;
			2'd2: c = SinA3;
			default: c = SinA1;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/lssw_engine.sv
// Sequencer and shared multiplier that compute the colour of one pixel.
`include "assert_macros.svh"

module lssw_engine
	import lssw_pkg::*;
#(
	parameter int NUM_WAVES  = DefNumWaves,
	parameter int PHASE_BITS = DefPhaseBits
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lssw_cfg_t         cfg,
	input  logic              start,
	input  logic [IndexW-1:0] pixel_index,
	input  logic              frame_end,
	input  logic              out_free,
	output logic              idle,
	output lssw_res_t         res
);

	localparam int WaveW = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
	localparam int SumW  = 32 + $clog2(NUM_WAVES + 1);
	localparam int QuadW = PHASE_BITS - 2;
	localparam logic [WaveW-1:0] LastWave = WaveW'(NUM_WAVES - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PIX_M, ST_PIX_W, ST_ANG, ST_U2_M, ST_U2_W, ST_P_M, ST_P_W,
		ST_V_M, ST_V_W, ST_TH, ST_G_M, ST_G_W, ST_FIN, ST_DONE
	} state_t;

	state_t                              state_q;
	logic [IndexW-1:0]                   idx_q;
	logic                                last_q;
	logic [WaveW-1:0]                    wave_q;
	logic [1:0]                          coef_q;
	logic [PHASE_BITS-1:0]               pix_q;
	logic [PHASE_BITS-1:0]               dstep_q;
	logic [1:0]                          quad_q;
	logic [MulW-1:0]                     u_q;
	logic [MulW-1:0]                     u2_q;
	logic [MulW-1:0]                     p_q;
	logic signed [15:0]                  s_q;
	logic [15:0]                         e_q;
	logic [SumW-1:0]                     sum_q;
	logic [7:0]                          red_q;
	logic [ProdW-1:0]                    prod_s1;
	logic [NUM_WAVES-1:0][PHASE_BITS-1:0] phase_q;

	logic [MulW-1:0]       mul_a;
	logic [MulW-1:0]       mul_b;
	logic [PHASE_BITS-1:0] ang;
	logic [QuadW:0]        mirr;
	logic [MulW-1:0]       prod_hi;
	logic [16:0]           v_rnd;
	logic [14:0]           v_mag;
	logic [23:0]           sum_clamp;
	logic [31:0]           sum_255;
	logic [PHASE_BITS-1:0] step_pb;

	// Operand selection of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PIX_M: begin
				mul_a = MulW'(idx_q);
				mul_b = MulW'(cfg.angle_per_pixel);
			end
			ST_U2_M: begin
				mul_a = u_q;
				mul_b = u_q;
			end
			ST_P_M: begin
				mul_a = u2_q;
				mul_b = p_q;
			end
			ST_V_M: begin
				mul_a = u_q;
				mul_b = p_q;
			end
			ST_G_M: begin
				mul_a = MulW'(e_q);
				mul_b = MulW'(cfg.wave_gain);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// The multiplier result is registered before anything uses it.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign prod_hi = prod_s1[ProdW-2:30];

	// Angle of the current wave, folded into the first quadrant.
	always_comb begin
		ang  = pix_q + phase_q[wave_q];
		mirr = {1'b0, ang[QuadW-1:0]};
		if (ang[QuadW]) begin
			mirr = (QuadW+1)'(1 << QuadW) - {1'b0, ang[QuadW-1:0]};
		end
	end

	// Round the polynomial to Q1.15 and saturate.
	always_comb begin
		v_rnd = 17'((32'(prod_hi) + 32'(1 << 14)) >> 15);
		v_mag = (v_rnd > 17'd32767) ? 15'd32767 : v_rnd[14:0];
	end

	// Clamp the sum to one and scale by 255.
	always_comb begin
		sum_clamp = (sum_q > SumW'(OneQ23)) ? 24'(OneQ23) : sum_q[23:0];
		sum_255   = {sum_clamp, 8'd0} - 32'(sum_clamp);
	end

	assign step_pb = PHASE_BITS'(cfg.phase_step);

	// Sequencer and its working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wave_q  <= '0;
			coef_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q   <= pixel_index;
						last_q  <= frame_end;
						sum_q   <= '0;
						wave_q  <= '0;
						dstep_q <= step_pb;
						state_q <= ST_PIX_M;
					end
				end
				ST_PIX_M: state_q <= ST_PIX_W;
				ST_PIX_W: begin
					pix_q   <= prod_s1[PHASE_BITS-1:0];
					state_q <= ST_ANG;
				end
				ST_ANG: begin
					quad_q  <= ang[PHASE_BITS-1:PHASE_BITS-2];
					u_q     <= MulW'(mirr) << (32 - PHASE_BITS);
					state_q <= ST_U2_M;
				end
				ST_U2_M: state_q <= ST_U2_W;
				ST_U2_W: begin
					u2_q    <= prod_hi;
					p_q     <= SinA9;
					coef_q  <= '0;
					state_q <= ST_P_M;
				end
				ST_P_M: state_q <= ST_P_W;
				ST_P_W: begin
					p_q    <= sin_coef(coef_q) - prod_hi;
					coef_q <= coef_q + 2'd1;
					if (coef_q == 2'd3) begin
						state_q <= ST_V_M;
					end else begin
						state_q <= ST_P_M;
					end
				end
				ST_V_M: state_q <= ST_V_W;
				ST_V_W: begin
					s_q     <= quad_q[1] ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
					state_q <= ST_TH;
				end
				ST_TH: begin
					e_q     <= (s_q >= cfg.wave_threshold) ? 16'(s_q - cfg.wave_threshold) : '0;
					state_q <= ST_G_M;
				end
				ST_G_M: state_q <= ST_G_W;
				ST_G_W: begin
					sum_q   <= sum_q + SumW'(prod_s1[31:0]);
					dstep_q <= dstep_q + step_pb;
					if (wave_q == LastWave) begin
						state_q <= ST_FIN;
					end else begin
						wave_q  <= wave_q + WaveW'(1);
						state_q <= ST_ANG;
					end
				end
				ST_FIN: begin
					red_q   <= sum_255[30:23];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Phase accumulators; a wave moves once its term is summed on the last pixel.
	for (genvar gk = 0; gk < NUM_WAVES; gk++) begin : g_phase
		localparam logic [PHASE_BITS-1:0] RstPhase =
			PHASE_BITS'(((64'(gk) << (PHASE_BITS + 1)) + 64'(NUM_WAVES)) / (2 * NUM_WAVES));
		localparam bit Backward = (gk % 2) == 0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				phase_q[gk] <= RstPhase;
			end else if (state_q == ST_G_W && last_q && wave_q == WaveW'(gk)) begin
				if (Backward) begin
					phase_q[gk] <= phase_q[gk] - dstep_q;
				end else begin
					phase_q[gk] <= phase_q[gk] + dstep_q;
				end
			end
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_DONE) && out_free;
	assign res.index = idx_q;
	assign res.red   = red_q;

	`ASSERT_IMP(a_start_idle, clk, arst_n, start, state_q == ST_IDLE, "item started while busy")
	`ASSERT_NXT(a_res_to_idle, clk, arst_n, res.valid, state_q == ST_IDLE, "result without return to idle")
	`ASSERT_NXT(a_phase_hold, clk, arst_n, state_q != ST_IDLE && !last_q, $stable(phase_q), "phase moved mid-frame")
	`ASSERT_NXT(a_sum_grows, clk, arst_n, state_q == ST_G_W, sum_q >= $past(sum_q), "wave sum decreased")

endmodule

// File: hdl/led_strip_sine_wave_pattern_core.sv
// Top level of the LED strip sine wave pattern core: register port, stream ports, output register.
//
// The core takes one pixel index per beat on the s_axis channel (tlast marks the last pixel of
// a frame) and returns one colour beat on the m_axis channel for every input beat, in order.
// Red and green carry the clamped sum of NUM_WAVES thresholded sine waves scaled to 0..255;
// blue is the blue_level register.
// One multiplier is shared by the pixel angle, the five-term sine polynomial and the gain, and
// every product is registered before use; each wave takes seven multiplies plus an angle step and
// a threshold step. On the last pixel of a frame each wave phase moves by its multiple of
// phase_step as its term is summed, even-numbered waves backward and odd-numbered ones forward.
// s_axis_tready is high only while the sequencer is idle; one pixel is in work at a time.
// The finished colour sits in an output register; while it waits for m_axis_tready the next
// pixel is already accepted, and a sequencer that finishes against a full register holds its
// result until the register frees.
// Reset clears both channels and loads the register defaults and the evenly spread start phases;
// no clearing pass is needed. The user must see that configuration is written only while the core
// is idle; the core itself leaves this unchecked.
module led_strip_sine_wave_pattern_core
	import lssw_pkg::*;
#(
	parameter int NUM_WAVES  = DefNumWaves,
	parameter int PHASE_BITS = DefPhaseBits
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Pixel input.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [9:0] pixel_index, [15:10] zero
	input  logic        s_axis_tlast,  // frame_end
	// Colour output.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [9:0] out_index, [17:10] red, [25:18] green,
	                                   // [33:26] blue, [39:34] zero
);

	lssw_cfg_t         cfg_q;
	lssw_res_t         res;
	lssw_reg_t         reg_sel;
	logic              wr_en;
	logic              idle;
	logic              start;
	logic              out_free;
	logic              m_valid_q;
	logic [IndexW-1:0] m_index_q;
	logic [7:0]        m_red_q;
	logic [7:0]        m_blue_q;

	assign pready  = 1'b1;
	assign reg_sel = lssw_reg_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_per_pixel <= RstAnglePerPixel;
			cfg_q.wave_threshold  <= RstWaveThreshold;
			cfg_q.wave_gain       <= RstWaveGain;
			cfg_q.blue_level      <= RstBlueLevel;
			cfg_q.phase_step      <= RstPhaseStep;
		end else if (wr_en) begin
			case (reg_sel)
				REG_ANGLE_PER_PIXEL: cfg_q.angle_per_pixel <= pwdata[15:0];
				REG_WAVE_THRESHOLD:  cfg_q.wave_threshold  <= $signed(pwdata[15:0]);
				REG_WAVE_GAIN:       cfg_q.wave_gain       <= pwdata[15:0];
				REG_BLUE_LEVEL:      cfg_q.blue_level      <= pwdata[7:0];
				REG_PHASE_STEP:      cfg_q.phase_step      <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_sel)
			REG_ANGLE_PER_PIXEL: prdata = 32'(cfg_q.angle_per_pixel);
			REG_WAVE_THRESHOLD:  prdata = 32'(unsigned'(cfg_q.wave_threshold));
			REG_WAVE_GAIN:       prdata = 32'(cfg_q.wave_gain);
			REG_BLUE_LEVEL:      prdata = 32'(cfg_q.blue_level);
			REG_PHASE_STEP:      prdata = 32'(cfg_q.phase_step);
			default:             prdata = '0;
		endcase
	end

	assign s_axis_tready = idle;
	assign start         = s_axis_tvalid && idle;
	assign out_free      = !m_valid_q || m_axis_tready;

	lssw_engine #(
		.NUM_WAVES  (NUM_WAVES),
		.PHASE_BITS (PHASE_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.start       (start),
		.pixel_index (s_axis_tdata[IndexW-1:0]),
		.frame_end   (s_axis_tlast),
		.out_free    (out_free),
		.idle        (idle),
		.res         (res)
	);

	// Output register; a new result loads when the register is empty or its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_index_q <= res.index;
			m_red_q   <= res.red;
			m_blue_q  <= cfg_q.blue_level;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_blue_q, m_red_q, m_red_q, m_index_q};

endmodule
